// ===== sv/pds_pkg.sv =====
// Package for the PLL divider search: widths, search limits and the
// status/result types shared by the sequencer and the top level.
// No dependencies.
package pds_pkg;

  localparam int REF_W      = 27;
  localparam int TARGET_W   = 28;
  localparam int M_W        = 6;
  localparam int N_W        = 9;
  localparam int P_W        = 2;
  localparam int Q_W        = 4;
  localparam int DIVIDEND_W = REF_W + N_W;  // ref * N
  localparam int DIVISOR_W  = M_W;          // M, P divisor and Q all fit here
  localparam int VCO_W      = 29;           // an in-range VCO is below 2^29

  localparam logic [REF_W-1:0] REF_RESET_HZ = REF_W'(16000000);

  localparam logic [M_W-1:0] M_LO       = M_W'(2);
  localparam logic [M_W-1:0] M_HI       = M_W'(63);
  localparam logic [N_W-1:0] N_LO       = N_W'(50);
  localparam logic [N_W-1:0] N_HI       = N_W'(432);
  localparam logic [P_W-1:0] P_FIRST    = P_W'(0);
  localparam logic [P_W-1:0] P_LAST     = P_W'(3);
  localparam logic [Q_W-1:0] Q_LO       = Q_W'(2);
  localparam logic [Q_W-1:0] Q_HI       = Q_W'(15);
  localparam logic [M_W-1:0] FALLBACK_M = M_W'(1);
  localparam logic [N_W-1:0] FALLBACK_N = N_W'(127);

  localparam logic [DIVIDEND_W-1:0] VIN_LO = DIVIDEND_W'(1000000);
  localparam logic [DIVIDEND_W-1:0] VIN_HI = DIVIDEND_W'(2000000);
  localparam logic [DIVIDEND_W-1:0] VCO_LO = DIVIDEND_W'(100000000);
  localparam logic [DIVIDEND_W-1:0] VCO_HI = DIVIDEND_W'(432000000);
  localparam logic [DIVIDEND_W-1:0] USB_LO = DIVIDEND_W'(47000000);
  localparam logic [DIVIDEND_W-1:0] USB_HI = DIVIDEND_W'(49000000);

  typedef struct packed {
    logic [M_W-1:0] pll_m;
    logic [N_W-1:0] pll_n;
    logic [P_W-1:0] p_code;
    logic           found;
  } pds_result_t;

  typedef struct packed {
    logic        idle;
    logic        done;
    pds_result_t result;
  } pds_status_t;

endpackage

// ===== sv/pds_in_if.sv =====
// Input channel of the PLL divider search: one target frequency per word.
// Depends on pds_pkg.
interface pds_in_if;
  logic                          valid;
  logic                          ready;
  logic [pds_pkg::TARGET_W-1:0]  target_sysclk_hz;

  modport source (output valid, output target_sysclk_hz, input ready);
  modport sink   (input valid, input target_sysclk_hz, output ready);
endinterface

// ===== sv/pds_out_if.sv =====
// Output channel of the PLL divider search: one divider set per word.
// Depends on pds_pkg.
interface pds_out_if;
  logic                     valid;
  logic                     ready;
  logic [pds_pkg::M_W-1:0]  pll_m;
  logic [pds_pkg::N_W-1:0]  pll_n;
  logic [pds_pkg::P_W-1:0]  p_code;
  logic                     found;

  modport source (output valid, output pll_m, output pll_n, output p_code, output found,
                  input ready);
  modport sink   (input valid, input pll_m, input pll_n, input p_code, input found,
                  output ready);
endinterface

// ===== sv/pll_divider_search.sv =====
// Top level of the PLL divider search: reference register, output register,
// sequencer and shared divider. Depends on pds_pkg, pds_in_if, pds_out_if,
// pds_seq and pds_divider.
//
//   channel   dir  handshake        word
//   in_i      in   valid/ready      target_sysclk_hz[27:0]
//   out_o     out  valid/ready      pll_m[5:0] pll_n[8:0] p_code[1:0] found
//   cfg       in   cfg_we_i         cfg_wdata_i[26:0] -> reference_clock_hz
//
// Search: every quotient comes from the one shared 36-step restoring divider.
// Per input word the sequencer divides ref by each of the 62 values of M; for
// each M whose ref/M is in window it sweeps the 383 values of N, checks the
// four P codes for each N with the VCO in range, and after an exact P match
// checks up to 14 values of Q. A hit stops the search early. Near a 64 MHz
// reference 32 values of M are in window.
// Reset: the reference returns to 16 MHz and the search stands idle.
// Stalls: in_i.ready is high whenever the sequencer is idle, also while a
// finished word waits in the output register; a new result waits inside the
// sequencer until that register is free.
module pll_divider_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pds_pkg::REF_W-1:0]  cfg_wdata_i,
  pds_in_if.sink                     in_i,
  pds_out_if.source                  out_o
);

  logic [pds_pkg::REF_W-1:0]       ref_q;
  logic                            out_valid_q;
  pds_pkg::pds_result_t            out_q;
  pds_pkg::pds_status_t            seq_status;
  logic                            slot_free;
  logic                            in_accept;

  logic                            div_start;
  logic [pds_pkg::DIVIDEND_W-1:0]  div_dividend;
  logic [pds_pkg::DIVISOR_W-1:0]   div_divisor;
  logic                            div_done;
  logic [pds_pkg::DIVIDEND_W-1:0]  div_quotient;

  // Reference clock register; the user must write it only while the search is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= pds_pkg::REF_RESET_HZ;
    end else if (cfg_we_i) begin
      ref_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = seq_status.idle;
  assign in_accept  = in_i.valid && seq_status.idle;

  // Output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (seq_status.done) begin
        out_valid_q <= 1'b1;
        out_q       <= seq_status.result;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.pll_m  = out_q.pll_m;
  assign out_o.pll_n  = out_q.pll_n;
  assign out_o.p_code = out_q.p_code;
  assign out_o.found  = out_q.found;

  pds_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (in_accept),
    .target_i       (in_i.target_sysclk_hz),
    .ref_i          (ref_q),
    .slot_free_i    (slot_free),
    .status_o       (seq_status),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quotient_i (div_quotient)
  );

  pds_divider #(
    .DIVIDEND_W (pds_pkg::DIVIDEND_W),
    .DIVISOR_W  (pds_pkg::DIVISOR_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // A result never overwrites a word that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q && $stable(out_q))
    else $error("pending output word was overwritten or dropped");
  // An accepted word always starts a search, so no new one starts while it runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !seq_status.idle)
    else $error("accepted word did not start a search");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_status.done |-> slot_free)
    else $error("result delivered into a full output register");

endmodule

// ===== sv/pds_divider.sv =====
// Restoring integer divider, one quotient bit per cycle.
// Depends on pds_pkg for default widths.
module pds_divider #(
  parameter int DIVIDEND_W = pds_pkg::DIVIDEND_W,
  parameter int DIVISOR_W  = pds_pkg::DIVISOR_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W+1:0]  diff;
  logic                  ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    ge     = ~diff[DIVISOR_W+1];
    rem_d  = ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    quo_d  = {quo_q[DIVIDEND_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W - 1);
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // The sequencer waits for each quotient before it issues the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while still busy");

endmodule

// ===== sv/pds_seq.sv =====
// Search sequencer: walks M, N, P and Q and reuses the one divider for every
// quotient. Depends on pds_pkg and drives pds_divider through plain ports.
module pds_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [pds_pkg::TARGET_W-1:0]    target_i,
  input  logic [pds_pkg::REF_W-1:0]       ref_i,
  input  logic                            slot_free_i,
  output pds_pkg::pds_status_t            status_o,
  output logic                            div_start_o,
  output logic [pds_pkg::DIVIDEND_W-1:0]  div_dividend_o,
  output logic [pds_pkg::DIVISOR_W-1:0]   div_divisor_o,
  input  logic                            div_done_i,
  input  logic [pds_pkg::DIVIDEND_W-1:0]  div_quotient_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_VIN, S_VCO_ISS, S_VCO, S_P, S_Q, S_NEXT_K, S_NEXT_N, S_NEXT_M, S_DONE
  } state_e;

  state_e                             state_q;
  logic [pds_pkg::M_W-1:0]            m_q;
  logic [pds_pkg::N_W-1:0]            n_q;
  logic [pds_pkg::P_W-1:0]            k_q;
  logic [pds_pkg::Q_W-1:0]            qdiv_q;
  logic [pds_pkg::VCO_W-1:0]          vco_q;
  logic [pds_pkg::TARGET_W-1:0]       target_q;
  logic                               found_q;
  logic                               start_q;
  logic [pds_pkg::DIVIDEND_W-1:0]     dividend_q;
  logic [pds_pkg::DIVISOR_W-1:0]      divisor_q;
  logic [pds_pkg::DIVIDEND_W-1:0]     prod;
  logic                               in_win_vin, in_win_vco, in_win_usb;

  assign prod       = ref_i * n_q;
  assign in_win_vin = (div_quotient_i >= pds_pkg::VIN_LO) && (div_quotient_i <= pds_pkg::VIN_HI);
  assign in_win_vco = (div_quotient_i >= pds_pkg::VCO_LO) && (div_quotient_i <= pds_pkg::VCO_HI);
  assign in_win_usb = (div_quotient_i >= pds_pkg::USB_LO) && (div_quotient_i <= pds_pkg::USB_HI);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_q        <= '0;
      n_q        <= '0;
      k_q        <= '0;
      qdiv_q     <= '0;
      vco_q      <= '0;
      target_q   <= '0;
      found_q    <= 1'b0;
      start_q    <= 1'b0;
      dividend_q <= '0;
      divisor_q  <= '0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            target_q   <= target_i;
            m_q        <= pds_pkg::M_LO;
            start_q    <= 1'b1;
            dividend_q <= pds_pkg::DIVIDEND_W'(ref_i);
            divisor_q  <= pds_pkg::DIVISOR_W'(pds_pkg::M_LO);
            state_q    <= S_VIN;
          end
        end
        S_VIN: begin
          if (div_done_i) begin
            if (in_win_vin) begin
              n_q     <= pds_pkg::N_LO;
              state_q <= S_VCO_ISS;
            end else begin
              state_q <= S_NEXT_M;
            end
          end
        end
        S_VCO_ISS: begin
          start_q    <= 1'b1;
          dividend_q <= prod;
          divisor_q  <= pds_pkg::DIVISOR_W'(m_q);
          state_q    <= S_VCO;
        end
        S_VCO: begin
          if (div_done_i) begin
            if (in_win_vco) begin
              // divide by two for the first output divider
              vco_q      <= div_quotient_i[pds_pkg::VCO_W-1:0];
              k_q        <= pds_pkg::P_FIRST;
              start_q    <= 1'b1;
              dividend_q <= div_quotient_i;
              divisor_q  <= pds_pkg::DIVISOR_W'(2);
              state_q    <= S_P;
            end else begin
              state_q <= S_NEXT_N;
            end
          end
        end
        S_P: begin
          if (div_done_i) begin
            if (div_quotient_i == pds_pkg::DIVIDEND_W'(target_q)) begin
              qdiv_q     <= pds_pkg::Q_LO;
              start_q    <= 1'b1;
              dividend_q <= pds_pkg::DIVIDEND_W'(vco_q);
              divisor_q  <= pds_pkg::DIVISOR_W'(pds_pkg::Q_LO);
              state_q    <= S_Q;
            end else begin
              state_q <= S_NEXT_K;
            end
          end
        end
        S_Q: begin
          if (div_done_i) begin
            if (in_win_usb) begin
              found_q <= 1'b1;
              state_q <= S_DONE;
            end else if (qdiv_q == pds_pkg::Q_HI) begin
              state_q <= S_NEXT_K;
            end else begin
              qdiv_q     <= qdiv_q + pds_pkg::Q_W'(1);
              start_q    <= 1'b1;
              dividend_q <= pds_pkg::DIVIDEND_W'(vco_q);
              divisor_q  <= pds_pkg::DIVISOR_W'(qdiv_q + pds_pkg::Q_W'(1));
            end
          end
        end
        S_NEXT_K: begin
          if (k_q == pds_pkg::P_LAST) begin
            state_q <= S_NEXT_N;
          end else begin
            // divisor is 2 * (code + 1) for the following code
            k_q        <= k_q + pds_pkg::P_W'(1);
            start_q    <= 1'b1;
            dividend_q <= pds_pkg::DIVIDEND_W'(vco_q);
            divisor_q  <= pds_pkg::DIVISOR_W'({3'(k_q) + 3'd2, 1'b0});
            state_q    <= S_P;
          end
        end
        S_NEXT_N: begin
          if (n_q == pds_pkg::N_HI) begin
            state_q <= S_NEXT_M;
          end else begin
            n_q     <= n_q + pds_pkg::N_W'(1);
            state_q <= S_VCO_ISS;
          end
        end
        S_NEXT_M: begin
          if (m_q == pds_pkg::M_HI) begin
            m_q     <= pds_pkg::FALLBACK_M;
            n_q     <= pds_pkg::FALLBACK_N;
            k_q     <= pds_pkg::P_FIRST;
            found_q <= 1'b0;
            state_q <= S_DONE;
          end else begin
            m_q        <= m_q + pds_pkg::M_W'(1);
            start_q    <= 1'b1;
            dividend_q <= pds_pkg::DIVIDEND_W'(ref_i);
            divisor_q  <= pds_pkg::DIVISOR_W'(m_q + pds_pkg::M_W'(1));
            state_q    <= S_VIN;
          end
        end
        S_DONE: begin
          // hold the result until the output register can take it
          if (slot_free_i) begin
            found_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign status_o.idle          = (state_q == S_IDLE);
  assign status_o.done          = (state_q == S_DONE) && slot_free_i;
  assign status_o.result.pll_m  = m_q;
  assign status_o.result.pll_n  = n_q;
  assign status_o.result.p_code = k_q;
  assign status_o.result.found  = found_q;

  assign div_start_o    = start_q;
  assign div_dividend_o = dividend_q;
  assign div_divisor_o  = divisor_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (state_q == S_VIN || state_q == S_VCO || state_q == S_P || state_q == S_Q))
    else $error("division issued outside a wait state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_i |-> (state_q == S_VIN || state_q == S_VCO || state_q == S_P || state_q == S_Q))
    else $error("quotient arrived while nobody waits for it");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && found_q) |-> (n_q >= pds_pkg::N_LO && n_q <= pds_pkg::N_HI
                                        && m_q >= pds_pkg::M_LO))
    else $error("hit reported with dividers outside the search range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !found_q) |-> (m_q == pds_pkg::FALLBACK_M
                                         && n_q == pds_pkg::FALLBACK_N
                                         && k_q == pds_pkg::P_FIRST))
    else $error("miss reported without the fallback dividers");

endmodule

// ===== dv/pds_divider_checker.sv =====
`timescale 1ns / 100ps
// Checker for the PLL divider search: recomputes each divider set from the
// watched target words and compares the result words in order.
// Depends on pds_pkg, pds_in_if and pds_out_if.
module pds_divider_checker
  import pds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [REF_W-1:0]  cfg_wdata_i,
  pds_in_if                 in_mon_i,
  pds_out_if                out_mon_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o,
  output int unsigned       results_o,
  output int unsigned       found_o
);

  logic [REF_W-1:0] reference_hz;
  pds_result_t      expected_dividers[$];

  // True when some Q divider brings the VCO into the 48 MHz window.
  function automatic bit usb_clock_reachable(input longint unsigned vco);
    longint unsigned f;
    for (int q = Q_LO; q <= Q_HI; q++) begin
      f = vco / q;
      if (f >= USB_LO && f <= USB_HI) return 1'b1;
    end
    return 1'b0;
  endfunction

  // First M, N, P hit in loop order, or the fallback set.
  function automatic pds_result_t search_dividers(input logic [REF_W-1:0]    ref_hz,
                                                  input logic [TARGET_W-1:0] target);
    pds_result_t     hit;
    longint unsigned hz, vin, vco;
    hz  = ref_hz;
    hit = '{pll_m: FALLBACK_M, pll_n: FALLBACK_N, p_code: P_FIRST, found: 1'b0};
    for (int m = M_LO; m <= M_HI; m++) begin
      vin = hz / m;
      if (vin < VIN_LO || vin > VIN_HI) continue;
      for (int n = N_LO; n <= N_HI; n++) begin
        vco = (hz * n) / m;
        if (vco < VCO_LO || vco > VCO_HI) continue;
        for (int k = P_FIRST; k <= P_LAST; k++) begin
          if (vco / (2 * (k + 1)) != target) continue;
          if (usb_clock_reachable(vco)) begin
            hit.pll_m  = M_W'(m);
            hit.pll_n  = N_W'(n);
            hit.p_code = P_W'(k);
            hit.found  = 1'b1;
            return hit;
          end
        end
      end
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_words
    pds_result_t got, want;
    if (!rst_ni) begin
      reference_hz = REF_RESET_HZ;
      expected_dividers.delete();
      mismatches_o = 0;
      results_o    = 0;
      found_o      = 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready)
        expected_dividers.push_back(search_dividers(reference_hz,
                                                    in_mon_i.target_sysclk_hz));
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = '{pll_m: out_mon_i.pll_m, pll_n: out_mon_i.pll_n,
                p_code: out_mon_i.p_code, found: out_mon_i.found};
        results_o++;
        if (expected_dividers.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%t: result word %0d arrived with nothing outstanding", $realtime,
                     results_o);
        end else begin
          want = expected_dividers.pop_front();
          if (want.found) found_o++;
          if (got.pll_m !== want.pll_m || got.pll_n !== want.pll_n ||
              got.p_code !== want.p_code || got.found !== want.found) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%t: word %0d expected M=%0d N=%0d P=%0d found=%0b, got M=%0d N=%0d P=%0d found=%0b",
                       $realtime, results_o, want.pll_m, want.pll_n, want.p_code, want.found,
                       got.pll_m, got.pll_n, got.p_code, got.found);
          end
        end
      end
      if (cfg_we_i) reference_hz = cfg_wdata_i;
    end
    pending_o = expected_dividers.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the PLL divider search: drives target words, reference
// settings and output back-pressure, and reports the checker's verdict.
// Depends on pds_pkg, pds_in_if, pds_out_if, pds_divider_checker and the block.
module tb_top;
  import pds_pkg::*;

  // Pause after the last result before touching the reference register.
  localparam int SETTLE_CYCLES    = 64;
  // Long output hold-off: long enough for several cheap searches to back up.
  localparam int LONG_HOLD_CYCLES = 20000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [REF_W-1:0]    cfg_wdata;

  int unsigned mismatches, words_pending, results_seen, sets_found;
  int unsigned words_sent, settings_used, input_stalls;

  // Drop all idling in the closing phase; arm the long hold-off once.
  bit quiet;
  bit hold_armed;

  pds_in_if  in_ch ();
  pds_out_if out_ch ();

  pll_divider_search i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  pds_divider_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (words_pending),
    .results_o    (results_seen),
    .found_o      (sets_found)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset at start, then release it away from the rising edge.
  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Count cycles where a target word waits on the block.
  always @(posedge clk) begin
    if (in_ch.valid && !in_ch.ready) input_stalls++;
  end

  // Hard stop: several times the slowest legal run.
  initial begin
    #1_000_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one target word, with an optional idle burst in front of it.
  task automatic send_target(input logic [TARGET_W-1:0] target);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.target_sysclk_hz <= target;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every outstanding result word is back.
  task automatic drain;
    in_ch.valid <= 1'b0;
    wait (words_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the reference only while the block is idle.
  task automatic set_reference(input logic [REF_W-1:0] hz);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Pick a target: mostly one reachable from a random M, N, P with the VCO
  // aimed at a 48 MHz band, else a near miss or a raw random word.
  function automatic logic [TARGET_W-1:0] pick_target(input logic [REF_W-1:0] hz);
    longint unsigned rhz, vco, n_lo, n_hi;
    int unsigned     m_pool[$];
    int unsigned     m, q, n, k, roll;
    rhz = hz;
    for (int i = M_LO; i <= M_HI; i++)
      if (rhz / i >= VIN_LO && rhz / i <= VIN_HI) m_pool.push_back(i);
    roll = $urandom_range(0, 9);
    if (m_pool.size() == 0 || roll == 0) return TARGET_W'($urandom());
    m = m_pool[$urandom_range(0, m_pool.size() - 1)];
    // Q of 3..9 are the only ones whose band meets the VCO range.
    q    = $urandom_range(3, 9);
    n_lo = (64'(USB_LO) * q * m + rhz - 1) / rhz;
    n_hi = (64'(USB_HI) * q * m) / rhz;
    if (n_lo < N_LO) n_lo = N_LO;
    if (n_hi > N_HI) n_hi = N_HI;
    if (n_lo > n_hi) n = $urandom_range(N_LO, N_HI);
    else             n = $urandom_range(int'(n_lo), int'(n_hi));
    vco = (rhz * n) / m;
    k   = $urandom_range(P_FIRST, P_LAST);
    // One word in ten is nudged off the exact match.
    return TARGET_W'(vco / (2 * (k + 1)) + (roll == 1));
  endfunction

  task automatic random_phase(input logic [REF_W-1:0] hz, input int count);
    set_reference(hz);
    repeat (count) send_target(pick_target(hz));
  endtask

  // Result side: random ready bursts, one long hold-off when armed.
  initial begin : result_sink
    bit held;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_armed && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    in_ch.valid            <= 1'b0;
    in_ch.target_sysclk_hz <= '0;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    settings_used          = 1;
    @(posedge rst_n);
    @(negedge clk);

    // Reset reference, 16 MHz: one hit per P code, plus 48 MHz via /4.
    send_target(28'd168_000_000);
    send_target(28'd84_000_000);
    send_target(28'd56_000_000);
    send_target(28'd42_000_000);
    send_target(28'd48_000_000);

    // 2 MHz: only M=2 is in window. Field extremes, N at its top, and a
    // target whose VCO matches but no Q lands in the USB window.
    set_reference(27'd2_000_000);
    send_target('0);
    send_target('1);
    send_target(28'd216_000_000);
    send_target(28'd50_000_000);
    send_target(28'd100_000_000);

    // 126 MHz: M=63 is the only divider in window.
    set_reference(27'd126_000_000);
    send_target(28'd168_000_000);
    send_target(28'd100_000_000);

    // Lowest nonzero reference: no M in window, always the fallback.
    set_reference(27'd1);
    send_target(28'd168_000_000);

    // Zero reference: runs as written, falls back.
    set_reference('0);
    send_target(28'd168_000_000);
    send_target('0);

    // Highest reference: ref/M never drops to 2 MHz.
    set_reference('1);
    send_target(28'h555_5555);
    send_target(28'hAAA_AAAA);

    // Typical 8 MHz crystal.
    set_reference(27'd8_000_000);
    send_target(28'd168_000_000);
    send_target(28'd72_000_000);

    // Random part, most words at references with few dividers in window.
    random_phase(27'd2_000_000, 32);
    random_phase(27'd2_500_000, 14);
    random_phase(27'd4_000_000, 10);

    // Cheap fallback searches while the result side holds off: fill the
    // block until it stalls the input.
    set_reference(27'd1);
    hold_armed = 1'b1;
    repeat (10) send_target(pick_target(27'd1));

    random_phase(27'd16_000_000, 6);
    random_phase(27'd8_000_000, 6);
    random_phase(27'd126_000_000, 6);
    random_phase('1, 4);

    // Closing phase back to back, no idling on either side.
    drain();
    quiet = 1'b1;
    random_phase(27'd3_000_000, 12);

    drain();
    $display("Covered %0d target words over %0d reference settings: %0d divider sets, %0d fallbacks.",
             words_sent, settings_used, sets_found, results_seen - sets_found);
    $display("Input stalled for %0d cycles, including one long result hold-off.",
             input_stalls);
    if (mismatches == 0 && words_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
